>>> design/kpd_pkg.sv
// shared types and constants for the ladder keypad debounce and auto-repeat core
// no dependencies; used by kpd_classify and ladder_keypad_debounce_autorepeat_core
package kpd_pkg;

  // field widths
  localparam int SampleW = 12;
  localparam int KeyW    = 3;
  localparam int DbW     = 4;
  localparam int RptW    = 8;
  localparam int SpeedW  = 2;
  localparam int AccelW  = 8;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  // register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_THR_NONE  = 3'd0,
    REG_THR_KEY1  = 3'd1,
    REG_THR_KEY2  = 3'd2,
    REG_THR_KEY3  = 3'd3,
    REG_THR_KEY4  = 3'd4,
    REG_INTERVALS = 3'd5,
    REG_DEBOUNCE  = 3'd6,
    REG_UNUSED    = 3'd7
  } reg_idx_t;

  // reset values of the registers
  localparam logic [SampleW-1:0] ThrNoneRst  = 12'd3400;
  localparam logic [SampleW-1:0] ThrKey1Rst  = 12'd2300;
  localparam logic [SampleW-1:0] ThrKey2Rst  = 12'd1435;
  localparam logic [SampleW-1:0] ThrKey3Rst  = 12'd690;
  localparam logic [SampleW-1:0] ThrKey4Rst  = 12'd157;
  localparam logic [DataW-1:0]   IntervalRst = 32'h0104_070F;
  localparam logic [DbW-1:0]     DebounceRst = 4'd3;

  // acceleration steps
  localparam logic [AccelW-1:0] AccelStep1 = 8'd50;
  localparam logic [AccelW-1:0] AccelStep2 = 8'd100;
  localparam logic [AccelW-1:0] AccelStep3 = 8'd200;

  // key codes
  localparam logic [KeyW-1:0] KeyNone = 3'd0;
  localparam logic [KeyW-1:0] Key1    = 3'd1;
  localparam logic [KeyW-1:0] Key2    = 3'd2;
  localparam logic [KeyW-1:0] Key3    = 3'd3;
  localparam logic [KeyW-1:0] Key4    = 3'd4;
  localparam logic [KeyW-1:0] Key5    = 3'd5;

  // ladder thresholds handed to the classifier
  typedef struct packed {
    logic [SampleW-1:0] none;
    logic [SampleW-1:0] key1;
    logic [SampleW-1:0] key2;
    logic [SampleW-1:0] key3;
    logic [SampleW-1:0] key4;
  } thresholds_t;

endpackage

>>> design/kpd_classify.sv
// ladder voltage classifier: maps one sample to a key level by descending thresholds
// depends on kpd_pkg
module kpd_classify (
  input  kpd_pkg::thresholds_t          thr,
  input  logic [kpd_pkg::SampleW-1:0]   sample,
  output logic [kpd_pkg::KeyW-1:0]      level
);

  // tests in fixed order, whatever the threshold ordering
  always_comb begin
    if (sample > thr.none) begin
      level = kpd_pkg::KeyNone;
    end else if (sample > thr.key1) begin
      level = kpd_pkg::Key1;
    end else if (sample > thr.key2) begin
      level = kpd_pkg::Key2;
    end else if (sample > thr.key3) begin
      level = kpd_pkg::Key3;
    end else if (sample > thr.key4) begin
      level = kpd_pkg::Key4;
    end else begin
      level = kpd_pkg::Key5;
    end
  end

endmodule

>>> design/ladder_keypad_debounce_autorepeat_core.sv
// top level of the ladder keypad debounce and accelerating auto-repeat core
// depends on kpd_pkg and kpd_classify
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   in       | in_valid, in_ready, sample                | request in
//   out      | out_valid, out_ready, key_event, key_level| request out
//   config   | psel, penable, pwrite, paddr, pwdata,     | apb slave
//            | prdata, pready                            |
//
// one request per clock sustained while results are taken; a request is held in an input register,
// then classified and applied to the key state on its way into the result register.
// a taken request's result is valid once it has passed the input register and then the result register.
// synchronous active-high reset clears all counters and loads register defaults.
// a stalled result keeps in_ready high until the input register is also full.
module ladder_keypad_debounce_autorepeat_core #(
  parameter int NUM_KEYS = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kpd_pkg::SampleW-1:0]   sample,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kpd_pkg::KeyW-1:0]      key_event,
  output logic [kpd_pkg::KeyW-1:0]      key_level,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kpd_pkg::AddrW-1:0]     paddr,
  input  logic [kpd_pkg::DataW-1:0]     pwdata,
  output logic [kpd_pkg::DataW-1:0]     prdata,
  output logic                          pready
);

  // configuration registers
  kpd_pkg::thresholds_t             thr;
  logic [kpd_pkg::DataW-1:0]        intervals;
  logic [kpd_pkg::DbW-1:0]          debounce_count;
  kpd_pkg::reg_idx_t                reg_idx;
  logic                             cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = kpd_pkg::reg_idx_t'(paddr[kpd_pkg::AddrW-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.none       <= kpd_pkg::ThrNoneRst;
      thr.key1       <= kpd_pkg::ThrKey1Rst;
      thr.key2       <= kpd_pkg::ThrKey2Rst;
      thr.key3       <= kpd_pkg::ThrKey3Rst;
      thr.key4       <= kpd_pkg::ThrKey4Rst;
      intervals      <= kpd_pkg::IntervalRst;
      debounce_count <= kpd_pkg::DebounceRst;
    end else if (cfg_write) begin
      unique case (reg_idx)
        kpd_pkg::REG_THR_NONE:  thr.none       <= pwdata[kpd_pkg::SampleW-1:0];
        kpd_pkg::REG_THR_KEY1:  thr.key1       <= pwdata[kpd_pkg::SampleW-1:0];
        kpd_pkg::REG_THR_KEY2:  thr.key2       <= pwdata[kpd_pkg::SampleW-1:0];
        kpd_pkg::REG_THR_KEY3:  thr.key3       <= pwdata[kpd_pkg::SampleW-1:0];
        kpd_pkg::REG_THR_KEY4:  thr.key4       <= pwdata[kpd_pkg::SampleW-1:0];
        kpd_pkg::REG_INTERVALS: intervals      <= pwdata;
        kpd_pkg::REG_DEBOUNCE:  debounce_count <= pwdata[kpd_pkg::DbW-1:0];
        default: ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      kpd_pkg::REG_THR_NONE:  prdata = kpd_pkg::DataW'(thr.none);
      kpd_pkg::REG_THR_KEY1:  prdata = kpd_pkg::DataW'(thr.key1);
      kpd_pkg::REG_THR_KEY2:  prdata = kpd_pkg::DataW'(thr.key2);
      kpd_pkg::REG_THR_KEY3:  prdata = kpd_pkg::DataW'(thr.key3);
      kpd_pkg::REG_THR_KEY4:  prdata = kpd_pkg::DataW'(thr.key4);
      kpd_pkg::REG_INTERVALS: prdata = intervals;
      kpd_pkg::REG_DEBOUNCE:  prdata = kpd_pkg::DataW'(debounce_count);
      default:                prdata = '0;
    endcase
  end

  // input register and flow control
  logic                           s_valid;
  logic [kpd_pkg::SampleW-1:0]    s_sample;
  logic                           advance;

  assign advance  = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_sample <= sample;
    end
  end

  // classification
  logic [kpd_pkg::KeyW-1:0] level;

  kpd_classify u_classify (
    .thr    (thr),
    .sample (s_sample),
    .level  (level)
  );

  // key state
  logic [kpd_pkg::DbW-1:0]     db_cnt      [NUM_KEYS];
  logic [kpd_pkg::DbW-1:0]     db_cnt_next [NUM_KEYS];
  logic [kpd_pkg::RptW-1:0]    repeat_counter, repeat_counter_next;
  logic [kpd_pkg::SpeedW-1:0]  repeat_speed, repeat_speed_next;
  logic [kpd_pkg::AccelW-1:0]  accel_counter, accel_counter_next;
  logic [kpd_pkg::KeyW-1:0]    ev;
  logic [kpd_pkg::RptW-1:0]    period;
  logic [kpd_pkg::RptW-1:0]    rpt_inc;
  logic [kpd_pkg::DbW-1:0]     db_inc;
  logic [kpd_pkg::AccelW-1:0]  accel_inc;

  // repeat period for the current speed
  always_comb begin
    case (repeat_speed)
      2'd0:    period = intervals[7:0];
      2'd1:    period = intervals[15:8];
      2'd2:    period = intervals[23:16];
      default: period = intervals[31:24];
    endcase
  end

  assign rpt_inc = repeat_counter + kpd_pkg::RptW'(1);

  // debounce and repeat update for the held key; other keys clear
  always_comb begin
    ev                  = kpd_pkg::KeyNone;
    repeat_counter_next = repeat_counter;
    repeat_speed_next   = repeat_speed;
    accel_counter_next  = accel_counter;
    db_inc              = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      db_cnt_next[k] = '0;
      if ({1'b0, level} == 4'(k + 1)) begin
        if (db_cnt[k] != debounce_count) begin
          db_inc         = db_cnt[k] + kpd_pkg::DbW'(1);
          db_cnt_next[k] = db_inc;
          if (db_inc == debounce_count) begin
            ev                  = level;
            repeat_counter_next = '0;
            repeat_speed_next   = '0;
            accel_counter_next  = '0;
          end
        end else begin
          db_cnt_next[k] = db_cnt[k];
          if (rpt_inc >= period) begin
            ev                  = level;
            repeat_counter_next = '0;
          end else begin
            repeat_counter_next = rpt_inc;
          end
        end
      end
    end
    // acceleration keeps running while the repeat counter is nonzero, until it reaches the last step
    accel_inc = accel_counter_next + kpd_pkg::AccelW'(1);
    if (repeat_counter_next != '0 && accel_counter_next != kpd_pkg::AccelStep3) begin
      accel_counter_next = accel_inc;
      if (accel_inc == kpd_pkg::AccelStep1) repeat_speed_next = 2'd1;
      if (accel_inc == kpd_pkg::AccelStep2) repeat_speed_next = 2'd2;
      if (accel_inc == kpd_pkg::AccelStep3) repeat_speed_next = 2'd3;
    end
  end

  // state update on each processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        db_cnt[k] <= '0;
      end
      repeat_counter <= '0;
      repeat_speed   <= '0;
      accel_counter  <= '0;
    end else if (advance) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        db_cnt[k] <= db_cnt_next[k];
      end
      repeat_counter <= repeat_counter_next;
      repeat_speed   <= repeat_speed_next;
      accel_counter  <= accel_counter_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      key_event <= ev;
      key_level <= level;
    end
  end

  // an event always names the key classified for the same sample
  assert property (@(posedge clk) disable iff (rst)
    out_valid && key_event != kpd_pkg::KeyNone |-> key_event == key_level)
    else $error("key event differs from key level");

  // acceleration counter saturates at the last step
  assert property (@(posedge clk) disable iff (rst)
    accel_counter <= kpd_pkg::AccelStep3)
    else $error("acceleration counter past last step");

  // speed follows the acceleration count
  assert property (@(posedge clk) disable iff (rst)
    (accel_counter < kpd_pkg::AccelStep1 |-> repeat_speed == 2'd0) and
    (accel_counter >= kpd_pkg::AccelStep3 |-> repeat_speed == 2'd3))
    else $error("repeat speed out of step with acceleration count");

  // any emitted event leaves the repeat counter cleared
  assert property (@(posedge clk) disable iff (rst)
    advance && ev != kpd_pkg::KeyNone |=> repeat_counter == '0)
    else $error("repeat counter not cleared after event");

endmodule
